@@ hw/rtl/mf2d_pkg.sv @@
package mf2d_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int KCFG_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam int RST_KERNEL = 3;
    localparam int RST_WIDTH  = 640;
    localparam int RST_HEIGHT = 480;

    // job queue between front and back
    localparam int Q_DEPTH = 2;

endpackage

@@ hw/rtl/mf2d_if.sv @@
interface mf2d_in_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [mf2d_pkg::PIX_W-1:0]    pixel;

    modport source (output valid, output command, output pixel, input ready);
    modport sink   (input valid, input command, input pixel, output ready);
endinterface

interface mf2d_out_if;
    logic                          valid;
    logic                          ready;
    logic [mf2d_pkg::PIX_W-1:0]    median;
    logic                          frame_last;

    modport source (output valid, output median, output frame_last, input ready);
    modport sink   (input valid, input median, input frame_last, output ready);
endinterface

interface mf2d_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mf2d_pkg::CFG_IDX_W-1:0]     index;
    logic [mf2d_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/mf2d_queue.sv @@
module mf2d_queue #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty,
    output logic              full
);

    localparam int PW = (mf2d_pkg::Q_DEPTH > 1) ? $clog2(mf2d_pkg::Q_DEPTH) : 1;
    localparam int CNTW = $clog2(mf2d_pkg::Q_DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [mf2d_pkg::Q_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]   cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg == CNTW'(mf2d_pkg::Q_DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(mf2d_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(mf2d_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/mf2d_front.sv @@
module mf2d_front #(
    parameter int MAX_KERNEL = 7,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic                                  command,
    input  logic [mf2d_pkg::PIX_W-1:0]            pixel,
    input  logic                                  cfg_valid,
    input  logic [mf2d_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mf2d_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  q_full,
    output logic                                  job_push,
    output logic [$clog2(MAX_HEIGHT)+$clog2(MAX_WIDTH)+2*$clog2(MAX_KERNEL+1):0] job_data,
    output logic                                  wr_en,
    output logic [$clog2((MAX_KERNEL+1)*MAX_WIDTH)-1:0] wr_addr,
    output logic [mf2d_pkg::PIX_W-1:0]            wr_data,
    output logic [$clog2(MAX_KERNEL+1)-1:0]       k_eff,
    output logic [$clog2(MAX_WIDTH+1)-1:0]        w_eff,
    output logic [$clog2(MAX_HEIGHT+1)-1:0]       h_eff
);

    localparam int KW = $clog2(MAX_KERNEL + 1);
    localparam int XW = $clog2(MAX_WIDTH + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int AW = $clog2((MAX_KERNEL + 1) * MAX_WIDTH);
    localparam int DW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int LW = (DW > KW + XW + 1) ? DW : KW + XW + 1;
    localparam int K_RST = (mf2d_pkg::RST_KERNEL < MAX_KERNEL) ? mf2d_pkg::RST_KERNEL : MAX_KERNEL;
    localparam int W_RST = (mf2d_pkg::RST_WIDTH < MAX_WIDTH) ? mf2d_pkg::RST_WIDTH : MAX_WIDTH;
    localparam int H_RST = (mf2d_pkg::RST_HEIGHT < MAX_HEIGHT) ? mf2d_pkg::RST_HEIGHT : MAX_HEIGHT;

    typedef struct packed {
        logic [RW-1:0] row;
        logic [CW-1:0] col;
        logic [KW-1:0] slot;
        logic [KW-1:0] pad;
        logic          last;
    } job_t;

    logic [KW-1:0] k_reg;
    logic [XW-1:0] w_reg;
    logic [HW-1:0] h_reg;
    logic [KW-1:0] k_clamp;
    logic [XW-1:0] w_clamp;
    logic [HW-1:0] h_clamp;

    logic [CW-1:0] in_col_reg, in_col_next;
    logic [HW-1:0] in_row_reg, in_row_next;
    logic [KW-1:0] in_slot_reg, in_slot_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;
    logic [KW-1:0] out_slot_reg, out_slot_next;
    logic [LW-1:0] d_reg, d_next;

    logic [KW-1:0] half;
    logic [KW-1:0] fwd;
    logic [XW-1:0] wm1;
    logic [XW-1:0] fwd_min;
    logic [LW-1:0] lag;
    logic          accept;
    logic          row_open;
    logic          do_write;
    logic          do_emit;
    logic          out_last;
    logic          cfg_wr;
    logic          cfg_known;
    job_t          job;

    // register clamping
    always_comb
    begin
        if (cfg_data[mf2d_pkg::KCFG_W-1:0] == '0)
        begin
            k_clamp = KW'(1);
        end
        else if (int'(cfg_data[mf2d_pkg::KCFG_W-1:0]) > MAX_KERNEL)
        begin
            k_clamp = KW'(MAX_KERNEL);
        end
        else
        begin
            k_clamp = KW'(cfg_data[mf2d_pkg::KCFG_W-1:0]);
        end
        if (cfg_data == '0)
        begin
            w_clamp = XW'(1);
            h_clamp = HW'(1);
        end
        else
        begin
            w_clamp = (int'(cfg_data) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(cfg_data);
            h_clamp = (int'(cfg_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_data);
        end
    end

    assign k_eff = k_reg;
    assign w_eff = w_reg;
    assign h_eff = h_reg;

    assign half    = k_reg >> 1;
    assign fwd     = k_reg - half - KW'(1);
    assign wm1     = w_reg - XW'(1);
    assign fwd_min = (XW'(fwd) < wm1) ? XW'(fwd) : wm1;
    assign lag     = LW'(fwd) * LW'(w_reg) + LW'(fwd_min);

    assign cfg_wr   = cfg_valid && cfg_known;
    assign accept   = in_valid && in_ready;
    assign row_open = (in_row_reg < h_reg);
    assign do_write = accept && (command == mf2d_pkg::CMD_PIXEL) && row_open;
    assign do_emit  = (do_write && (d_reg >= lag)) || (accept && !row_open);
    assign out_last = (HW'(out_row_reg) == h_reg - HW'(1)) && (XW'(out_col_reg) == wm1);

    assign wr_en   = do_write;
    assign wr_addr = AW'(in_slot_reg) * AW'(MAX_WIDTH) + AW'(in_col_reg);
    assign wr_data = pixel;

    always_comb
    begin
        job.row  = out_row_reg;
        job.col  = out_col_reg;
        job.slot = out_slot_reg;
        job.pad  = '0;
        job.last = out_last;
    end

    assign job_push = do_emit;
    assign job_data = job;

    always_comb
    begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_slot_next  = in_slot_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_slot_next = out_slot_reg;
        d_next        = d_reg;
        if (do_write)
        begin
            d_next = d_reg + LW'(1);
            if (XW'(in_col_reg) == wm1)
            begin
                in_col_next  = '0;
                in_row_next  = in_row_reg + HW'(1);
                in_slot_next = (in_slot_reg == k_reg) ? '0 : in_slot_reg + KW'(1);
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end
        end
        if (do_emit)
        begin
            d_next = d_next - LW'(1);
            if (XW'(out_col_reg) == wm1)
            begin
                out_col_next  = '0;
                out_row_next  = out_row_reg + RW'(1);
                out_slot_next = (out_slot_reg == k_reg) ? '0 : out_slot_reg + KW'(1);
            end
            else
            begin
                out_col_next = out_col_reg + CW'(1);
            end
        end
        // end of frame or register write: restart the frame
        if ((do_emit && out_last) || cfg_wr)
        begin
            in_col_next   = '0;
            in_row_next   = '0;
            in_slot_next  = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            out_slot_next = '0;
            d_next        = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg        <= KW'(K_RST);
            w_reg        <= XW'(W_RST);
            h_reg        <= HW'(H_RST);
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            d_reg        <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    mf2d_pkg::REG_KERNEL: k_reg <= k_clamp;
                    mf2d_pkg::REG_WIDTH:  w_reg <= w_clamp;
                    mf2d_pkg::REG_HEIGHT: h_reg <= h_clamp;
                    default: ;
                endcase
            end
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_slot_reg  <= in_slot_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_slot_reg <= out_slot_next;
            d_reg        <= d_next;
        end
    end

    // an index beyond the list restarts nothing
    assign cfg_known = (cfg_index == mf2d_pkg::REG_KERNEL) || (cfg_index == mf2d_pkg::REG_WIDTH)
                    || (cfg_index == mf2d_pkg::REG_HEIGHT);

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !q_full)
        else $error("job pushed into full queue");

    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (job_push && job.last && !cfg_valid) |=> (in_row_reg == '0 && d_reg == '0 && out_row_reg == '0))
        else $error("frame counters not cleared after last result");

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_known) |=> (in_col_reg == '0 && out_col_reg == '0))
        else $error("register write did not restart frame");

endmodule

@@ hw/rtl/mf2d_back.sv @@
module mf2d_back #(
    parameter int MAX_KERNEL = 7,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [$clog2(MAX_KERNEL+1)-1:0]       k_eff,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]        w_eff,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]       h_eff,
    input  logic                                  job_valid,
    input  logic [$clog2(MAX_HEIGHT)+$clog2(MAX_WIDTH)+2*$clog2(MAX_KERNEL+1):0] job_data,
    output logic                                  job_pop,
    input  logic                                  wr_en,
    input  logic [$clog2((MAX_KERNEL+1)*MAX_WIDTH)-1:0] wr_addr,
    input  logic [mf2d_pkg::PIX_W-1:0]            wr_data,
    output logic                                  busy,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [mf2d_pkg::PIX_W-1:0]            median,
    output logic                                  frame_last
);

    localparam int KW    = $clog2(MAX_KERNEL + 1);
    localparam int XW    = $clog2(MAX_WIDTH + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int AW    = $clog2((MAX_KERNEL + 1) * MAX_WIDTH);
    localparam int DEPTH = (MAX_KERNEL + 1) * MAX_WIDTH;
    localparam int WIN   = MAX_KERNEL * MAX_KERNEL;
    localparam int NW    = $clog2(WIN + 1);
    localparam int IW    = (WIN > 1) ? $clog2(WIN) : 1;
    localparam int YW    = HW + 1;
    localparam int XSW   = XW + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_TAIL = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    typedef struct packed {
        logic [RW-1:0] row;
        logic [CW-1:0] col;
        logic [KW-1:0] slot;
        logic [KW-1:0] pad;
        logic          last;
    } job_t;

    logic [mf2d_pkg::PIX_W-1:0] mem [DEPTH];

    job_t          job;
    logic [1:0]    state_reg, state_next;
    logic [KW-1:0] dy_reg, dy_next;
    logic [KW-1:0] dx_reg, dx_next;
    logic [YW-1:0] y_reg, y_next;
    logic [XSW-1:0] x_reg, x_next;
    logic [XSW-1:0] x0_reg, x0_next;
    logic [KW-1:0] slot_reg, slot_next;
    logic          last_reg, last_next;
    logic [NW-1:0] n_reg, n_next;
    logic          rd_flag_reg;
    logic [mf2d_pkg::PIX_W-1:0] rd_data_reg;
    logic [mf2d_pkg::PIX_W-1:0] win_reg [WIN];
    logic [mf2d_pkg::PIX_W-1:0] win_next [WIN];
    logic [WIN-1:0] le;
    logic          out_valid_reg;
    logic [mf2d_pkg::PIX_W-1:0] median_reg;
    logic          frame_last_reg;

    logic [KW-1:0] half;
    logic [KW-1:0] slot0;
    logic          inb;
    logic [AW-1:0] rd_addr;
    logic          issue;
    logic          out_free;

    assign job      = job_t'(job_data);
    assign half     = k_eff >> 1;
    assign slot0    = (job.slot >= half) ? job.slot - half
                    : KW'({1'b0, job.slot} + {1'b0, k_eff} + (KW+1)'(1) - {1'b0, half});
    assign busy     = (state_reg != ST_IDLE);
    assign job_pop  = (state_reg == ST_IDLE) && job_valid;
    assign issue    = (state_reg == ST_RUN);
    assign inb      = !y_reg[YW-1] && (y_reg[YW-2:0] < h_eff)
                   && !x_reg[XSW-1] && (x_reg[XSW-2:0] < w_eff);
    assign rd_addr  = AW'(slot_reg) * AW'(MAX_WIDTH) + AW'(x_reg[XSW-2:0]);
    assign out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign median     = median_reg;
    assign frame_last = frame_last_reg;

    // line store: one write port from the front, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // insertion into the sorted window, all entries in parallel
    always_comb
    begin
        for (int i = 0; i < WIN; i++)
        begin
            le[i] = (NW'(i) < n_reg) && (win_reg[i] <= rd_data_reg);
        end
        for (int i = 0; i < WIN; i++)
        begin
            if (!rd_flag_reg || le[i])
            begin
                win_next[i] = win_reg[i];
            end
            else if (i == 0)
            begin
                win_next[i] = rd_data_reg;
            end
            else if (le[i-1])
            begin
                win_next[i] = rd_data_reg;
            end
            else
            begin
                win_next[i] = win_reg[i-1];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dy_next    = dy_reg;
        dx_next    = dx_reg;
        y_next     = y_reg;
        x_next     = x_reg;
        x0_next    = x0_reg;
        slot_next  = slot_reg;
        last_next  = last_reg;
        n_next     = rd_flag_reg ? n_reg + NW'(1) : n_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = ST_RUN;
                    dy_next    = '0;
                    dx_next    = '0;
                    y_next     = YW'(job.row) - YW'(half);
                    x_next     = XSW'(job.col) - XSW'(half);
                    x0_next    = XSW'(job.col) - XSW'(half);
                    slot_next  = slot0;
                    last_next  = job.last;
                    n_next     = '0;
                end
            end
            ST_RUN:
            begin
                if (dx_reg == k_eff - KW'(1))
                begin
                    dx_next   = '0;
                    x_next    = x0_reg;
                    dy_next   = dy_reg + KW'(1);
                    y_next    = y_reg + YW'(1);
                    slot_next = (slot_reg == k_eff) ? '0 : slot_reg + KW'(1);
                    if (dy_reg == k_eff - KW'(1))
                    begin
                        state_next = ST_TAIL;
                    end
                end
                else
                begin
                    dx_next = dx_reg + KW'(1);
                    x_next  = x_reg + XSW'(1);
                end
            end
            ST_TAIL:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_flag_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_flag_reg <= issue && inb;
            n_reg       <= n_next;
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dy_reg   <= dy_next;
        dx_reg   <= dx_next;
        y_reg    <= y_next;
        x_reg    <= x_next;
        x0_reg   <= x0_next;
        slot_reg <= slot_next;
        last_reg <= last_next;
        for (int i = 0; i < WIN; i++)
        begin
            win_reg[i] <= win_next[i];
        end
        if (state_reg == ST_DONE && out_free)
        begin
            median_reg     <= win_reg[IW'(n_reg >> 1)];
            frame_last_reg <= last_reg;
        end
    end

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (dy_reg < k_eff && dx_reg < k_eff))
        else $error("window scan out of range");

    a_win_room: assert property (@(posedge clk) disable iff (!rst_n)
        rd_flag_reg |-> (n_reg < NW'(WIN)))
        else $error("window overflow");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !out_ready) |=> (state_reg == ST_DONE))
        else $error("result overwritten while output stalled");

endmodule

@@ hw/rtl/median_filter_2d_gray_core.sv @@
// channel   dir   beat fields                 accepted when
// in_ch     in    command, pixel              valid && ready
// out_ch    out   median, frame_last          valid && ready
// cfg_ch    in    index, data                 valid (ready tied high)
//
// A beat that causes no result leaves the input ready; the next beat may follow at once.
// A beat that causes a result holds the input while the back end reads the window
// from the line store one pixel per cycle through its single read port, inserting as it goes.
// The result waits in an output register; new beats are taken while it is stalled there, but
// the next result stalls the input until the earlier one has left.
// Reset clears control only; the line store holds garbage until the frame writes it.
module median_filter_2d_gray_core #(
    parameter int MAX_KERNEL = 7,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    mf2d_in_if.sink      in_ch,
    mf2d_out_if.source   out_ch,
    mf2d_cfg_if.sink     cfg_ch
);

    localparam int KW    = $clog2(MAX_KERNEL + 1);
    localparam int XW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int AW    = $clog2((MAX_KERNEL + 1) * MAX_WIDTH);
    localparam int JOB_W = $clog2(MAX_HEIGHT) + $clog2(MAX_WIDTH) + 2 * KW + 1;

    logic                       job_push;
    logic [JOB_W-1:0]           job_data;
    logic [JOB_W-1:0]           q_data;
    logic                       q_empty;
    logic                       q_full;
    logic                       job_pop;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [mf2d_pkg::PIX_W-1:0] wr_data;
    logic [KW-1:0]              k_eff;
    logic [XW-1:0]              w_eff;
    logic [HW-1:0]              h_eff;
    logic                       back_busy;
    logic                       front_ready;

    // one job in flight at a time keeps the line ring from being overwritten under the scan
    assign front_ready  = q_empty && !back_busy;
    assign in_ch.ready  = front_ready;
    assign cfg_ch.ready = 1'b1;

    mf2d_front #(
        .MAX_KERNEL (MAX_KERNEL),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (front_ready),
        .command   (in_ch.command),
        .pixel     (in_ch.pixel),
        .cfg_valid (cfg_ch.valid),
        .cfg_index (cfg_ch.index),
        .cfg_data  (cfg_ch.data),
        .q_full    (q_full),
        .job_push  (job_push),
        .job_data  (job_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .k_eff     (k_eff),
        .w_eff     (w_eff),
        .h_eff     (h_eff)
    );

    mf2d_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_data),
        .pop       (job_pop),
        .pop_data  (q_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    mf2d_back #(
        .MAX_KERNEL (MAX_KERNEL),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .k_eff      (k_eff),
        .w_eff      (w_eff),
        .h_eff      (h_eff),
        .job_valid  (!q_empty),
        .job_data   (q_data),
        .job_pop    (job_pop),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .busy       (back_busy),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .median     (out_ch.median),
        .frame_last (out_ch.frame_last)
    );

endmodule

@@ test/mf2d_scoreboard.sv @@
module mf2d_scoreboard (
    input  logic        clk,
    input  logic        rst_n,
    mf2d_in_if.sink     in_mon,
    mf2d_out_if.sink    out_mon,
    mf2d_cfg_if.sink    cfg_mon,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING = 8;
    localparam int LW   = 1024;

    typedef struct packed {
        logic [mf2d_pkg::PIX_W-1:0] median;
        logic                       frame_last;
    } median_beat_t;

    logic [mf2d_pkg::PIX_W-1:0] rows [RING*LW];
    int unsigned kern, wid, hgt;
    int unsigned icol, irow, ocol, orow;
    median_beat_t due_q [$];

    assign pending = due_q.size();

    function automatic int unsigned sat(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // window median at the output position, then step the output raster
    task automatic emit_median();
        int unsigned k, w, h, n, p;
        int back, y, x;
        logic [mf2d_pkg::PIX_W-1:0] srt [49];
        logic [mf2d_pkg::PIX_W-1:0] v;
        median_beat_t r;
        k = sat(kern, 1, 7); w = sat(wid, 1, 1024); h = sat(hgt, 1, 1024);
        back = k / 2;
        n = 0;
        for (int dy = 0; dy < k; dy++)
        begin
            y = int'(orow) - back + dy;
            if (y < 0 || y >= int'(h)) continue;
            for (int dx = 0; dx < k; dx++)
            begin
                x = int'(ocol) - back + dx;
                if (x < 0 || x >= int'(w)) continue;
                v = rows[(y % (k + 1)) * LW + x];
                p = n;
                while (p > 0 && srt[p-1] > v)
                begin
                    srt[p] = srt[p-1];
                    p--;
                end
                srt[p] = v;
                n++;
            end
        end
        r.median = srt[n/2];
        r.frame_last = (orow == h - 1) && (ocol == w - 1);
        due_q.push_back(r);
        if (r.frame_last)
        begin
            icol = 0; irow = 0; ocol = 0; orow = 0;
        end
        else
        begin
            ocol++;
            if (ocol >= w)
            begin
                ocol = 0;
                orow++;
            end
        end
    endtask

    task automatic take_item(input logic cmd, input logic [mf2d_pkg::PIX_W-1:0] pix);
        int unsigned k, w, h, fwd, lag, t, o;
        k = sat(kern, 1, 7); w = sat(wid, 1, 1024); h = sat(hgt, 1, 1024);
        fwd = k - k/2 - 1;
        lag = fwd * w + ((fwd < w - 1) ? fwd : w - 1);
        if (cmd == mf2d_pkg::CMD_PIXEL && irow < h)
        begin
            t = irow * w + icol;
            o = orow * w + ocol;
            rows[(irow % (k + 1)) * LW + icol] = pix;
            icol++;
            if (icol >= w)
            begin
                icol = 0;
                irow++;
            end
            if (t >= o && t - o >= lag) emit_median();
        end
        else if (irow >= h && orow < h)
            emit_median();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kern = mf2d_pkg::RST_KERNEL;
            wid  = mf2d_pkg::RST_WIDTH;
            hgt  = mf2d_pkg::RST_HEIGHT;
            icol = 0; irow = 0; ocol = 0; orow = 0;
            fail_count = 0;
            due_q.delete();
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                if (due_q.size() == 0)
                    report("unexpected beat", int'(out_mon.median), -1);
                else
                begin
                    median_beat_t e;
                    e = due_q.pop_front();
                    if (out_mon.median !== e.median)
                        report("median", int'(out_mon.median), int'(e.median));
                    if (out_mon.frame_last !== e.frame_last)
                        report("frame_last", int'(out_mon.frame_last), int'(e.frame_last));
                end
            end
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                case (cfg_mon.index)
                    mf2d_pkg::REG_KERNEL: kern = 32'(cfg_mon.data[mf2d_pkg::KCFG_W-1:0]);
                    mf2d_pkg::REG_WIDTH:  wid  = 32'(cfg_mon.data);
                    mf2d_pkg::REG_HEIGHT: hgt  = 32'(cfg_mon.data);
                    default: ;
                endcase
                if (cfg_mon.index inside {mf2d_pkg::REG_KERNEL, mf2d_pkg::REG_WIDTH,
                                          mf2d_pkg::REG_HEIGHT})
                begin
                    icol = 0; irow = 0; ocol = 0; orow = 0;
                end
            end
            if (in_mon.valid && in_mon.ready)
                take_item(in_mon.command, in_mon.pixel);
        end
    end

endmodule

@@ test/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PW = mf2d_pkg::PIX_W;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   hold_off;
    int   sent;
    bit   rx_stall_on;

    mf2d_in_if  in_ch();
    mf2d_out_if out_ch();
    mf2d_cfg_if cfg_ch();

    median_filter_2d_gray_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    mf2d_scoreboard u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (in_ch.sink),
        .out_mon    (out_ch.sink),
        .cfg_mon    (cfg_ch.sink),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver: own stall pattern, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_off > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else if (rx_stall_on)
            out_ch.ready <= ($urandom_range(0, 3) != 0);
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
        if (rst_n && $urandom_range(0, 199) == 0) rx_stall_on <= !rx_stall_on;

    task automatic send(input logic cmd, input logic [PW-1:0] pix);
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.pixel   <= pix;
        do @(posedge clk); while (!in_ch.ready);
        sent++;
    endtask

    task automatic pause(input int n);
        in_ch.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // bursts and gaps around one beat
    task automatic send_bursty(input logic cmd, input logic [PW-1:0] pix);
        send(cmd, pix);
        if ($urandom_range(0, 7) == 0) pause($urandom_range(1, 6));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mf2d_pkg::CFG_IDX_W-1:0] idx, input int val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val[mf2d_pkg::CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frame(input int k, input int w, input int h);
        write_reg(mf2d_pkg::REG_KERNEL, k);
        write_reg(mf2d_pkg::REG_WIDTH, w);
        write_reg(mf2d_pkg::REG_HEIGHT, h);
    endtask

    // one frame of pixels (random, black and white, or a ramp by mode), then surplus beats to drain it;
    // some noise flushes early
    task automatic run_frame(input int k, input int w, input int h, input int mode);
        logic [PW-1:0] p;
        int ke, fwd, extra;
        ke = (k < 1) ? 1 : ((k > 7) ? 7 : k);
        fwd = ke - ke / 2 - 1;
        extra = fwd * w + fwd + 3;
        for (int i = 0; i < w * h; i++)
        begin
            case (mode)
                0: p = PW'($urandom_range(0, 255));
                1: p = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                default: p = PW'(i);
            endcase
            if ($urandom_range(0, 19) == 0) send_bursty(mf2d_pkg::CMD_FLUSH, PW'($urandom));
            send_bursty(mf2d_pkg::CMD_PIXEL, p);
        end
        // surplus: pixels after the last one act as flushes
        for (int i = 0; i < extra; i++)
            send_bursty($urandom_range(0, 3) != 0 ? mf2d_pkg::CMD_FLUSH : mf2d_pkg::CMD_PIXEL,
                        PW'($urandom));
    endtask

    initial
    begin
        int k, w, h;
        rst_n = 1'b0;
        hold_off = 0;
        sent = 0;
        rx_stall_on = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.command = mf2d_pkg::CMD_PIXEL;
        in_ch.pixel = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = mf2d_pkg::REG_KERNEL;
        cfg_ch.data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, clamped registers, tiny frames
        set_frame(1, 1, 1);
        send(mf2d_pkg::CMD_FLUSH, 8'hAA);
        send(mf2d_pkg::CMD_PIXEL, 8'hFF);
        send(mf2d_pkg::CMD_FLUSH, 8'h00);
        send(mf2d_pkg::CMD_PIXEL, 8'h00);
        drain();
        set_frame(0, 3, 2);
        run_frame(0, 3, 2, 2);
        drain();
        set_frame(7, 2, 3);
        run_frame(7, 2, 3, 1);
        drain();
        set_frame(2, 0, 1);
        run_frame(2, 1, 1, 0);
        drain();
        set_frame(4, 1, 4);
        run_frame(4, 1, 4, 0);
        drain();

        // long receiver hold-off while sending, then full pause till drained
        set_frame(3, 6, 5);
        hold_off = 0;
        fork
            begin
                @(posedge clk);
                hold_off <= 300;
            end
            run_frame(3, 6, 5, 0);
        join
        drain();

        while (sent < 1330)
        begin
            k = $urandom_range(1, 7);
            w = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
            h = (w > 40) ? $urandom_range(1, 2) : $urandom_range(1, 10);
            if ($urandom_range(0, 9) == 0) k = 7;
            if ($urandom_range(0, 14) == 0) write_reg(mf2d_pkg::REG_KERNEL, 0);
            set_frame(k, w, h);
            run_frame(k, w, h, $urandom_range(0, 5) == 0 ? 1 : 0);
            // mid-frame register write restarts the frame
            if ($urandom_range(0, 5) == 0)
            begin
                drain();
                set_frame(k, w, h);
                for (int i = 0; i < (w * h) / 2; i++)
                    send_bursty(mf2d_pkg::CMD_PIXEL, PW'($urandom));
                drain();
                write_reg(mf2d_pkg::REG_HEIGHT, h);
            end
            drain();
        end

        // width saturated to its maximum: no frame end among the first pixels
        set_frame(2, 1024, 1024);
        write_reg(mf2d_pkg::REG_WIDTH, 2047);
        write_reg(mf2d_pkg::REG_HEIGHT, 1);
        for (int i = 0; i < 60; i++)
            send_bursty(mf2d_pkg::CMD_PIXEL, PW'($urandom));
        drain();
        write_reg(mf2d_pkg::REG_KERNEL, 3);

        if (fail_count == 0)
            $display("PASS median_filter_2d_gray_core");
        else
            $display("FAIL median_filter_2d_gray_core");
        $finish;
    end

    initial
    begin
        #60ms;
        $display("FAIL median_filter_2d_gray_core");
        $finish;
    end

endmodule
